/* rtl/core/assert_macros.svh */
// Assertion macros shared by the pair-force RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LJ_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LJ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lj_pkg.sv */
// Shared widths, constants, types and helper functions of the pair-force pipeline.
`timescale 1ns / 1ps

package lj_pkg;

    // Field widths
    localparam int POS_W     = 32;   // Q15.16 position
    localparam int CFG_W     = 31;   // register width
    localparam int CFG_IDX_W = 2;
    localparam int F_W       = 48;   // force field
    localparam int E_W       = 64;   // energy field

    // Datapath widths
    localparam int D_W    = 34;      // wrapped separation, signed
    localparam int DW_W   = D_W + 2; // working width of the wrap
    localparam int DM_W   = 32;      // clamped |d|
    localparam int SQ_W   = 64;      // one squared axis
    localparam int SUM_W  = 66;      // sum of three squares
    localparam int R2_W   = 62;      // divisor, r2 below cutoff^2 < 2^62
    localparam int S_W    = 39;      // 1/r2, 32 fraction bits
    localparam int S4_W   = 46;
    localparam int S6_W   = 52;
    localparam int S8_W   = 59;
    localparam int S12_W  = 56;
    localparam int G_W    = S6_W + 1;
    localparam int P_W    = G_W + S8_W - 32;
    localparam int FMAG_W = 42;      // force factor magnitude, 32 fraction bits
    localparam int M_W    = 42;      // force magnitude

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd3;

    localparam logic [CFG_W-1:0] BOX_RESET    = 31'd655360;
    localparam logic [CFG_W-1:0] CUTOFF_RESET = 31'd163840;

    // Arithmetic constants
    localparam logic [SUM_W-1:0]  R2_FLOOR   = 66'd42949673;     // 0.01, 32 fraction bits
    localparam logic [FMAG_W-1:0] FACTOR_CAP = 42'd4294967296000; // 1000.0
    localparam logic [P_W-1:0]    P_CAP      = 80'd178956970666;  // cap / 24
    localparam logic [DM_W-1:0]   MAG_CLAMP  = 32'h8000_0000;

    // Per-pair data that rides beside the power chain
    typedef struct packed {
        logic            in_range;
        logic [2:0]      neg;     // sign of d, z..x
        logic [DM_W-1:0] mag_z;
        logic [DM_W-1:0] mag_y;
        logic [DM_W-1:0] mag_x;
    } pair_side_t;

    // Data that rides beside the factor and force multipliers
    typedef struct packed {
        pair_side_t             pair;
        logic                   gneg;
        logic signed [E_W-1:0]  energy;
    } fac_side_t;

    // Result word, force_x in the lowest bits
    typedef struct packed {
        logic signed [E_W-1:0] pair_energy;
        logic signed [F_W-1:0] force_z;
        logic signed [F_W-1:0] force_y;
        logic signed [F_W-1:0] force_x;
    } res_t;

    // One minimum-image wrap of a - b against box length len
    function automatic logic signed [D_W-1:0] wrap_axis(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b,
        input logic        [CFG_W-1:0] len
    );
        logic signed [DW_W-1:0] d;
        logic signed [DW_W-1:0] l;
        logic signed [DW_W-1:0] tw;
        d  = DW_W'(a) - DW_W'(b);
        l  = signed'(DW_W'(len));
        tw = d <<< 1;
        if (tw > l) begin
            d = d - l;
        end else if (tw < -l) begin
            d = d + l;
        end
        return D_W'(d);
    endfunction

    // |d| clamped to 2^31
    function automatic logic [DM_W-1:0] clamp_mag(input logic signed [D_W-1:0] d);
        logic [D_W-1:0] m;
        m = d[D_W-1] ? D_W'(-d) : D_W'(d);
        if (m > D_W'(MAG_CLAMP)) begin
            return MAG_CLAMP;
        end
        return m[DM_W-1:0];
    endfunction

endpackage

/* rtl/core/lj_mul.sv */
// Two-stage unsigned multiplier: four registered 32x32 partial products, then sum and shift.
`timescale 1ns / 1ps

module lj_mul #(
    parameter int WA     = 64,
    parameter int WB     = 64,
    parameter int SH     = 32,
    parameter int WO     = 64,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vin,
    input  logic [WA-1:0]     a,
    input  logic [WB-1:0]     b,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vout,
    output logic [WO-1:0]     prod,
    output logic [SIDE_W-1:0] side_out
);

    localparam int HW = 32;

    logic [2*HW-1:0]   a_ext, b_ext;
    logic [2*HW-1:0]   pp00_next, pp01_next, pp10_next, pp11_next;
    logic [2*HW-1:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [4*HW-1:0]   sum_next;
    logic [WO-1:0]     prod_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg;
    logic              v1_reg, v2_reg;

    // Partial products
    assign a_ext     = (2*HW)'(a);
    assign b_ext     = (2*HW)'(b);
    assign pp00_next = a_ext[HW-1:0]    * b_ext[HW-1:0];
    assign pp01_next = a_ext[HW-1:0]    * b_ext[2*HW-1:HW];
    assign pp10_next = a_ext[2*HW-1:HW] * b_ext[HW-1:0];
    assign pp11_next = a_ext[2*HW-1:HW] * b_ext[2*HW-1:HW];

    // Recombination
    assign sum_next = (4*HW)'(pp00_reg)
                    + ((4*HW)'(pp01_reg) << HW)
                    + ((4*HW)'(pp10_reg) << HW)
                    + ((4*HW)'(pp11_reg) << (2*HW));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp00_reg  <= pp00_next;
            pp01_reg  <= pp01_next;
            pp10_reg  <= pp10_next;
            pp11_reg  <= pp11_next;
            side1_reg <= side_in;
            prod_reg  <= WO'(sum_next >> SH);
            side2_reg <= side1_reg;
        end
    end

    assign vout     = v2_reg;
    assign prod     = prod_reg;
    assign side_out = side2_reg;

endmodule

/* rtl/core/lj_recip.sv */
// Pipelined restoring divider: floor(2^64 / den), one quotient bit per stage.
`timescale 1ns / 1ps

module lj_recip import lj_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vin,
    input  logic [R2_W-1:0]   den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vout,
    output logic [S_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    // Numerator bits above the quotient field enter as the first remainder
    localparam logic [R2_W-1:0] REM_INIT = R2_W'(1) << (64 - S_W);

    logic              vld_reg  [S_W];
    logic [R2_W-1:0]   rem_reg  [S_W];
    logic [R2_W-1:0]   den_reg  [S_W];
    logic [S_W-1:0]    quo_reg  [S_W];
    logic [SIDE_W-1:0] side_reg [S_W];

    for (genvar k = 0; k < S_W; k++) begin : g_step
        logic              v_in;
        logic [R2_W-1:0]   rem_in, den_in;
        logic [S_W-1:0]    quo_in;
        logic [SIDE_W-1:0] sd_in;
        logic [R2_W:0]     twice;
        logic              take;
        logic [R2_W-1:0]   rem_next;

        if (k == 0) begin : g_first
            assign v_in   = vin;
            assign rem_in = REM_INIT;
            assign den_in = den;
            assign quo_in = '0;
            assign sd_in  = side_in;
        end else begin : g_next
            assign v_in   = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign sd_in  = side_reg[k-1];
        end

        // Shift in a zero bit, subtract when the divisor fits
        assign twice    = {rem_in, 1'b0};
        assign take     = (twice >= {1'b0, den_in});
        assign rem_next = take ? (twice[R2_W-1:0] - den_in) : twice[R2_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= {quo_in[S_W-2:0], take};
                side_reg[k] <= sd_in;
            end
        end
    end

    assign vout     = vld_reg[S_W-1];
    assign quo      = quo_reg[S_W-1];
    assign side_out = side_reg[S_W-1];

endmodule

/* rtl/core/lj_pow.sv */
// Inverse powers of a squared distance: s = 1/r2, then s6, s8 and s12.
`timescale 1ns / 1ps

module lj_pow import lj_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vin,
    input  logic [R2_W-1:0]   r2,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vout,
    output logic [S6_W-1:0]   s6,
    output logic [S8_W-1:0]   s8,
    output logic [S12_W-1:0]  s12,
    output logic [SIDE_W-1:0] side_out
);

    logic                    v_s, v_s4, v_s6;
    logic [S_W-1:0]          s;
    logic [S4_W-1:0]         s4;
    logic [S6_W-1:0]         s6_w;
    logic [SIDE_W-1:0]       side_s;
    logic [SIDE_W+S_W-1:0]   side_s4, side_s6;
    logic [SIDE_W+S6_W-1:0]  side_s8;

    // Reciprocal, 32 fraction bits
    lj_recip #(.SIDE_W(SIDE_W)) u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vin      (vin),
        .den      (r2),
        .side_in  (side_in),
        .vout     (v_s),
        .quo      (s),
        .side_out (side_s)
    );

    // s4 = s*s
    lj_mul #(.WA(S_W), .WB(S_W), .SH(32), .WO(S4_W), .SIDE_W(SIDE_W + S_W)) u_mul_s4 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vin      (v_s),
        .a        (s),
        .b        (s),
        .side_in  ({side_s, s}),
        .vout     (v_s4),
        .prod     (s4),
        .side_out (side_s4)
    );

    // s6 = s4*s
    lj_mul #(.WA(S4_W), .WB(S_W), .SH(32), .WO(S6_W), .SIDE_W(SIDE_W + S_W)) u_mul_s6 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vin      (v_s4),
        .a        (s4),
        .b        (side_s4[S_W-1:0]),
        .side_in  (side_s4),
        .vout     (v_s6),
        .prod     (s6_w),
        .side_out (side_s6)
    );

    // s8 = s6*s, carrying s6 along
    lj_mul #(.WA(S6_W), .WB(S_W), .SH(32), .WO(S8_W), .SIDE_W(SIDE_W + S6_W)) u_mul_s8 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vin      (v_s6),
        .a        (s6_w),
        .b        (side_s6[S_W-1:0]),
        .side_in  ({side_s6[SIDE_W+S_W-1:S_W], s6_w}),
        .vout     (vout),
        .prod     (s8),
        .side_out (side_s8)
    );

    // s12 = s6*s6 / 2^48, in step with s8
    lj_mul #(.WA(S6_W), .WB(S6_W), .SH(48), .WO(S12_W), .SIDE_W(1)) u_mul_s12 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vin      (v_s6),
        .a        (s6_w),
        .b        (s6_w),
        .side_in  (1'b0),
        .vout     (),
        .prod     (s12),
        .side_out ()
    );

    assign s6       = side_s8[S6_W-1:0];
    assign side_out = side_s8[SIDE_W+S6_W-1:S6_W];

endmodule

/* rtl/core/lennard_jones_pair_force.sv */
// Lennard-Jones pair force and shifted energy with minimum-image wrap, fully pipelined.
//
//  Port group  Dir  Payload                                             Handshake
//  s_*         in   pair of positions (first_x..second_z)               tvalid/tready
//  m_*         out  force_x, force_y, force_z, pair_energy; in_range    tvalid/tready
//  cfg_*       in   box_x, box_y, box_z, cutoff_radius                  write enable only
//
//  One item per clock while the skid register is free; the path to m_tvalid has 57 register stages.
//  The stages are five front-end stages, the 39-stage reciprocal divider (one quotient bit
//  per stage), five two-stage multipliers in series and three single registers.
//  aresetn is synchronous; it clears valid bits and restores the register defaults.
//  A full skid register freezes the whole pipeline; an item waiting in the output
//  register alone does not stop acceptance. There is no memory and no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lennard_jones_pair_force import lj_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [6*POS_W-1:0]   s_tdata,
    // force_x, force_y, force_z (48 bits each), pair_energy (64 bits)
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [$bits(res_t)-1:0] m_tdata,
    // in_range
    output logic [0:0]           m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [G_W-1:0] ONE_Q32 = G_W'(1) << 32;
    localparam logic [G_W-1:0] HALF_Q32 = G_W'(1) << 31;
    localparam int PS_W = $bits(pair_side_t);
    localparam int FS_W = $bits(fac_side_t);

    logic [CFG_W-1:0]        box_x_reg, box_y_reg, box_z_reg, cutoff_reg;
    logic [R2_W-1:0]         c2_reg;
    logic                    adv;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v8_reg;
    logic signed [D_W-1:0]   d_reg    [3];
    logic [DM_W-1:0]         mag2_reg [3];
    logic [DM_W-1:0]         mag3_reg [3];
    logic [DM_W-1:0]         mag4_reg [3];
    logic [SQ_W-1:0]         sq3_reg  [3];
    logic [2:0]              neg2_reg, neg3_reg, neg4_reg;
    logic [SUM_W-1:0]        sum4_reg;
    logic [SUM_W-1:0]        r2f;
    logic [R2_W-1:0]         den5_reg;
    pair_side_t              side5_reg;

    logic                    pv;
    logic [S6_W-1:0]         s6, c6;
    logic [S8_W-1:0]         s8;
    logic [S12_W-1:0]        s12, c12;
    pair_side_t              pside;

    logic [G_W-1:0]          two_s6, g_next;
    logic                    gneg_next;
    logic [E_W-1:0]          energy_next;
    logic [G_W-1:0]          g6_reg;
    logic [S8_W-1:0]         s8_6_reg;
    fac_side_t               side6_reg;

    logic                    v7;
    logic [P_W-1:0]          p7, p24;
    fac_side_t               side7;
    logic [FMAG_W-1:0]       fmag8_reg;
    fac_side_t               side8_reg;

    logic                    fin_valid;
    logic [M_W-1:0]          m_x, m_y, m_z;
    fac_side_t               fin_side;
    res_t                    fin;

    logic                    out_valid_reg, skid_valid_reg;
    res_t                    out_data_reg, skid_data_reg;
    logic                    out_range_reg, skid_range_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg  <= BOX_RESET;
            box_y_reg  <= BOX_RESET;
            box_z_reg  <= BOX_RESET;
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BOX_X:  box_x_reg  <= cfg_data;
                CFG_BOX_Y:  box_y_reg  <= cfg_data;
                CFG_BOX_Z:  box_z_reg  <= cfg_data;
                CFG_CUTOFF: cutoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Squared cutoff, held steady between writes
    always_ff @(posedge aclk) begin
        c2_reg <= R2_W'(cutoff_reg) * R2_W'(cutoff_reg);
    end

    // Pipeline moves whenever the skid register is free
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // Valid bits of the front end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Front end: wrap, magnitude, squares, sum, floor and cutoff test
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0] <= wrap_axis(s_tdata[0*POS_W +: POS_W], s_tdata[3*POS_W +: POS_W],
                                  box_x_reg);
            d_reg[1] <= wrap_axis(s_tdata[1*POS_W +: POS_W], s_tdata[4*POS_W +: POS_W],
                                  box_y_reg);
            d_reg[2] <= wrap_axis(s_tdata[2*POS_W +: POS_W], s_tdata[5*POS_W +: POS_W],
                                  box_z_reg);
            for (int k = 0; k < 3; k++) begin
                mag2_reg[k] <= clamp_mag(d_reg[k]);
                neg2_reg[k] <= d_reg[k][D_W-1];
                sq3_reg[k]  <= SQ_W'(mag2_reg[k]) * SQ_W'(mag2_reg[k]);
                mag3_reg[k] <= mag2_reg[k];
                mag4_reg[k] <= mag3_reg[k];
            end
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            sum4_reg <= SUM_W'(sq3_reg[0]) + SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);
            den5_reg <= r2f[R2_W-1:0];
            side5_reg.in_range <= (r2f < SUM_W'(c2_reg));
            side5_reg.neg      <= neg4_reg;
            side5_reg.mag_x    <= mag4_reg[0];
            side5_reg.mag_y    <= mag4_reg[1];
            side5_reg.mag_z    <= mag4_reg[2];
        end
    end

    assign r2f = (sum4_reg < R2_FLOOR) ? R2_FLOOR : sum4_reg;

    // Powers of 1/r2 for the pair
    lj_pow #(.SIDE_W(PS_W)) u_pow_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vin      (v5_reg),
        .r2       (den5_reg),
        .side_in  (side5_reg),
        .vout     (pv),
        .s6       (s6),
        .s8       (s8),
        .s12      (s12),
        .side_out (pside)
    );

    // Powers of 1/rc^2, free running on the held cutoff
    lj_pow #(.SIDE_W(1)) u_pow_c (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (1'b1),
        .vin      (1'b1),
        .r2       (c2_reg),
        .side_in  (1'b0),
        .vout     (),
        .s6       (c6),
        .s8       (),
        .s12      (c12),
        .side_out ()
    );

    // Shifted energy and g = 2*s6 - 1
    assign two_s6      = G_W'(s6) << 1;
    assign gneg_next   = (G_W'(s6) < HALF_Q32);
    assign g_next      = gneg_next ? (ONE_Q32 - two_s6) : (two_s6 - ONE_Q32);
    assign energy_next = (E_W'(s12) - E_W'(s6 >> 16) - E_W'(c12) + E_W'(c6 >> 16)) << 2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g6_reg           <= g_next;
            s8_6_reg         <= s8;
            side6_reg.pair   <= pside;
            side6_reg.gneg   <= gneg_next;
            side6_reg.energy <= signed'(energy_next);
        end
    end

    // p = |g| * s8
    lj_mul #(.WA(G_W), .WB(S8_W), .SH(32), .WO(P_W), .SIDE_W(FS_W)) u_mul_p (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vin      (v6_reg),
        .a        (g6_reg),
        .b        (s8_6_reg),
        .side_in  (side6_reg),
        .vout     (v7),
        .prod     (p7),
        .side_out (side7)
    );

    // Force factor magnitude 24*p, capped at 1000
    assign p24 = p7 * P_W'(24);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (adv) begin
            v8_reg <= v7;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fmag8_reg <= (p7 > P_CAP) ? FACTOR_CAP : p24[FMAG_W-1:0];
            side8_reg <= side7;
        end
    end

    // Force magnitudes per axis
    lj_mul #(.WA(FMAG_W), .WB(DM_W), .SH(32), .WO(M_W), .SIDE_W(FS_W)) u_mul_fx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vin      (v8_reg),
        .a        (fmag8_reg),
        .b        (side8_reg.pair.mag_x),
        .side_in  (side8_reg),
        .vout     (fin_valid),
        .prod     (m_x),
        .side_out (fin_side)
    );

    lj_mul #(.WA(FMAG_W), .WB(DM_W), .SH(32), .WO(M_W), .SIDE_W(1)) u_mul_fy (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vin      (v8_reg),
        .a        (fmag8_reg),
        .b        (side8_reg.pair.mag_y),
        .side_in  (1'b0),
        .vout     (),
        .prod     (m_y),
        .side_out ()
    );

    lj_mul #(.WA(FMAG_W), .WB(DM_W), .SH(32), .WO(M_W), .SIDE_W(1)) u_mul_fz (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .vin      (v8_reg),
        .a        (fmag8_reg),
        .b        (side8_reg.pair.mag_z),
        .side_in  (1'b0),
        .vout     (),
        .prod     (m_z),
        .side_out ()
    );

    // Signs and out-of-range zeroing; magnitudes stay well inside 48 bits
    always_comb begin
        fin = '0;
        if (fin_side.pair.in_range) begin
            fin.force_x     = (fin_side.gneg != fin_side.pair.neg[0]) ? -F_W'(m_x) : F_W'(m_x);
            fin.force_y     = (fin_side.gneg != fin_side.pair.neg[1]) ? -F_W'(m_y) : F_W'(m_y);
            fin.force_z     = (fin_side.gneg != fin_side.pair.neg[2]) ? -F_W'(m_z) : F_W'(m_z);
            fin.pair_energy = fin_side.energy;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_data_reg   <= skid_data_reg;
                    out_range_reg  <= skid_range_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (fin_valid) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= fin;
                    out_range_reg <= fin_side.pair.in_range;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg  <= fin;
                    skid_range_reg <= fin_side.pair.in_range;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_range_reg;

    `LJ_ASSERT(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid item without an output item")
    `LJ_ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg, "skid item dropped while stalled")
    `LJ_ASSERT(a_out_of_range_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "out-of-range item carries data")
    `LJ_ASSERT_NEXT(a_drain, aclk, aresetn, out_valid_reg && m_tready && !skid_valid_reg && !fin_valid, !out_valid_reg, "output item repeated")

endmodule
